>>> design/mbc_pkg.sv
package mbc_pkg;

  localparam int ROUNDS    = 32;
  localparam int KEY_WORDS = 4;
  localparam int ADDR_W    = 5;
  localparam int IDX_W     = 2;

  // register indexes, byte address is 8 * index
  typedef enum logic [IDX_W-1:0] {
    REG_KEY_WORD_0 = 2'd0,
    REG_KEY_WORD_1 = 2'd1,
    REG_KEY_WORD_2 = 2'd2,
    REG_KEY_WORD_3 = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic        dec;
    logic [31:0] left;
    logic [31:0] right;
  } stage_t;

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'hC, 4'h4, 4'h6, 4'h2, 4'hA, 4'h5, 4'hB, 4'h9,
      4'hE, 4'h8, 4'hD, 4'h7, 4'h0, 4'h3, 4'hF, 4'h1},
    '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'hA, 4'h5, 4'hC,
      4'h1, 4'hE, 4'h4, 4'h7, 4'hB, 4'hD, 4'h0, 4'hF},
    '{4'hB, 4'h3, 4'h5, 4'h8, 4'h2, 4'hF, 4'hA, 4'hD,
      4'hE, 4'h1, 4'h7, 4'h4, 4'hC, 4'h9, 4'h6, 4'h0},
    '{4'hC, 4'h8, 4'h2, 4'h1, 4'hD, 4'h4, 4'hF, 4'h6,
      4'h7, 4'h0, 4'hA, 4'h5, 4'h3, 4'hE, 4'h9, 4'hB},
    '{4'h7, 4'hF, 4'h5, 4'hA, 4'h8, 4'h1, 4'h6, 4'hD,
      4'h0, 4'h9, 4'h3, 4'hE, 4'hB, 4'h4, 4'h2, 4'hC},
    '{4'h5, 4'hD, 4'hF, 4'h6, 4'h9, 4'h2, 4'hC, 4'hA,
      4'hB, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'hE, 4'h0},
    '{4'h8, 4'hE, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hC,
      4'hF, 4'h4, 4'hB, 4'h0, 4'hD, 4'hA, 4'h3, 4'h7},
    '{4'h1, 4'h7, 4'hE, 4'hD, 4'h0, 4'h5, 4'h8, 4'h3,
      4'h4, 4'hF, 4'hA, 4'h6, 4'h9, 4'hC, 4'hB, 4'h2}
  };

  // round key number for schedule position pos
  function automatic logic [2:0] sched_index(input int pos);
    logic [2:0] low;
    low = pos[2:0];
    if (pos < 24) return low;
    return 3'd7 - low;
  endfunction

  function automatic logic [31:0] round_fn(input logic [31:0] half, input logic [31:0] k);
    logic [31:0] x;
    logic [31:0] y;
    x = half + k;
    for (int n = 0; n < 8; n++) begin
      y[4*n +: 4] = SBOX[n][x[4*n +: 4]];
    end
    return {y[20:0], y[31:21]};
  endfunction

endpackage

>>> design/mbc_if.sv
interface mbc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] block_in;

  modport source (output valid, output command, output block_in, input ready);
  modport sink (input valid, input command, input block_in, output ready);
endinterface

interface mbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out;

  modport source (output valid, output block_out, input ready);
  modport sink (input valid, input block_out, output ready);
endinterface

>>> design/mbc_round.sv
module mbc_round (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [31:0]     key,
  input  mbc_pkg::stage_t stage_in,
  output mbc_pkg::stage_t stage_out
);
  import mbc_pkg::*;

  logic [31:0] nl;

  assign nl = stage_in.left ^ round_fn(stage_in.right, key);

  // halves always swap here, the final unswap is done at the output
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (en) begin
      stage_out.valid <= stage_in.valid;
    end
    if (en) begin
      stage_out.dec   <= stage_in.dec;
      stage_out.left  <= stage_in.right;
      stage_out.right <= nl;
    end
  end

endmodule

>>> design/magma_block_cipher.sv
// channel  dir  payload                     handshake
// req      in   command[0:0], block_in[63:0]  valid/ready
// rsp      out  block_out[63:0]               valid/ready
// apb      in   key words 0..3 at 0x00..0x18  psel/penable, pready tied high
//
// one round per register stage, 32 stages: a word accepted at one edge passes through
// every round stage in order and then shows on rsp; one word is taken every cycle unless the pipeline holds.
// rst clears the stage valid bits and the key words.
// the whole pipeline holds when the last stage is full and rsp is not taken;
// req.ready follows that same enable, so nothing is dropped or repeated.
module magma_block_cipher (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mbc_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  mbc_in_if.sink                     req,
  mbc_out_if.source                  rsp
);
  import mbc_pkg::*;

  logic [63:0]      key_word [KEY_WORDS];
  logic [31:0]      sub_key [8];
  logic [IDX_W-1:0] reg_idx;
  logic             en;
  stage_t           stage [ROUNDS+1];

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign prdata  = key_word[reg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_WORDS; i++) key_word[i] <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_KEY_WORD_0: key_word[0] <= pwdata;
        REG_KEY_WORD_1: key_word[1] <= pwdata;
        REG_KEY_WORD_2: key_word[2] <= pwdata;
        REG_KEY_WORD_3: key_word[3] <= pwdata;
        default: ;
      endcase
    end
  end

  // even round keys sit in the high half of their word
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      if ((j % 2) == 0) sub_key[j] = key_word[KEY_WORDS-1-(j/2)][63:32];
      else              sub_key[j] = key_word[KEY_WORDS-1-(j/2)][31:0];
    end
  end

  assign en        = !stage[ROUNDS].valid || rsp.ready;
  assign req.ready = en;

  assign stage[0] = {req.valid, req.command, req.block_in};

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam logic [2:0] ENC_IDX = sched_index(r);
    localparam logic [2:0] DEC_IDX = sched_index(ROUNDS - 1 - r);
    logic [31:0] key;

    assign key = (stage[r].dec == CMD_DECRYPT) ? sub_key[DEC_IDX] : sub_key[ENC_IDX];

    mbc_round u_round (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .key      (key),
      .stage_in (stage[r]),
      .stage_out(stage[r+1])
    );
  end

  // undo the swap of the final round
  assign rsp.valid     = stage[ROUNDS].valid;
  assign rsp.block_out = {stage[ROUNDS].right, stage[ROUNDS].left};

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (stage[1].valid && stage[1].dec == $past(req.command)))
    else $error("accepted word did not enter the first stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(stage[1].valid) && $stable(stage[ROUNDS].valid)
             && $stable(rsp.block_out)))
    else $error("pipeline moved during a stall");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (en && stage[ROUNDS-1].valid) |=> rsp.valid)
    else $error("word lost before the output stage");

endmodule
